FILE: rtl/core/asf_pkg.sv
package asf_pkg;

	// Configuration port geometry
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int IDX_W  = 2;

	// Register indexes (byte address = 4 * index)
	localparam logic [IDX_W-1:0] REG_THRESHOLD   = 2'd0;
	localparam logic [IDX_W-1:0] REG_FIRST_INDEX = 2'd1;
	localparam logic [IDX_W-1:0] REG_LAYER_ID    = 2'd2;

	localparam int MAX_SAMPLES_DEF = 4096;

	// Result queue depth; two slots must be free to take a word
	localparam int OUTQ_DEPTH = 4;

	typedef struct packed {
		logic [14:0] threshold;
		logic [15:0] first_index;
		logic [3:0]  layer_id;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  layer;
		logic [15:0] start_idx;
		logic [15:0] stop_idx;
		logic        last;
	} strip_t;

	// Results produced by one accepted word: count 0..2, first in r0
	typedef struct packed {
		logic [1:0] cnt;
		strip_t     r0;
		strip_t     r1;
	} push_t;

endpackage

FILE: rtl/core/asf_regs.sv
module asf_regs import asf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output cfg_t              cfg
);

	logic             wr_en;
	logic [IDX_W-1:0] idx;
	cfg_t             cfg_q;

	assign idx   = paddr[ADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_THRESHOLD:   cfg_q.threshold   <= pwdata[14:0];
				REG_FIRST_INDEX: cfg_q.first_index <= pwdata[15:0];
				REG_LAYER_ID:    cfg_q.layer_id    <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_THRESHOLD:   prdata = {17'd0, cfg_q.threshold};
			REG_FIRST_INDEX: prdata = {16'd0, cfg_q.first_index};
			REG_LAYER_ID:    prdata = {28'd0, cfg_q.layer_id};
			default:         prdata = '0;
		endcase
	end

endmodule

FILE: rtl/core/asf_step.sv
module asf_step import asf_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               acc,
	input  logic signed [15:0] sample,
	input  logic               last_sample,
	output push_t              push
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

	logic [15:0]      pos_q, open_begin_q, held_begin_q, held_end_q, last_above_q;
	logic [CNT_W-1:0] cnt_q;
	logic             at_start_q, in_strip_q, held_q;

	logic [15:0]      pos, open_begin_n, held_begin_n, held_end_n, last_above_n, flush_end;
	logic [CNT_W-1:0] cnt;
	logic             active, above, nonpos, closing, emit_conf, flush;
	logic             in_strip_n, held_n;
	strip_t           conf_s, flush_s;

	// Activity start loads the index base
	assign pos    = at_start_q ? cfg.first_index : pos_q;
	assign cnt    = at_start_q ? '0 : cnt_q;
	assign active = cnt < CNT_W'(MAX_SAMPLES);
	assign above  = active && (sample > $signed({1'b0, cfg.threshold}));
	assign nonpos = sample[15] || (sample == '0);
	assign closing   = active && !above && in_strip_q && nonpos;
	assign emit_conf = above && held_q;

	always_comb begin
		in_strip_n   = in_strip_q;
		held_n       = held_q;
		open_begin_n = open_begin_q;
		held_begin_n = held_begin_q;
		held_end_n   = held_end_q;
		last_above_n = last_above_q;
		if (above) begin
			last_above_n = pos;
			held_n       = 1'b0;
			in_strip_n   = 1'b1;
			if (!in_strip_q)
				open_begin_n = pos;
		end else if (closing) begin
			held_n       = 1'b1;
			held_begin_n = open_begin_q;
			held_end_n   = pos;
			in_strip_n   = 1'b0;
		end
	end

	assign flush     = last_sample && (held_n || in_strip_n);
	assign flush_end = last_above_n + 16'd1;

	always_comb begin
		conf_s.layer     = cfg.layer_id;
		conf_s.start_idx = held_begin_q;
		conf_s.stop_idx  = held_end_q;
		conf_s.last      = !flush;
		flush_s.layer     = cfg.layer_id;
		flush_s.start_idx = held_n ? held_begin_n : open_begin_n;
		flush_s.stop_idx  = flush_end;
		flush_s.last      = 1'b1;
	end

	always_comb begin
		push.cnt = acc ? ({1'b0, emit_conf} + {1'b0, flush}) : 2'd0;
		push.r0  = emit_conf ? conf_s : flush_s;
		push.r1  = flush_s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			in_strip_q <= 1'b0;
			held_q     <= 1'b0;
			cnt_q      <= '0;
		end else if (acc) begin
			if (last_sample) begin
				at_start_q <= 1'b1;
				in_strip_q <= 1'b0;
				held_q     <= 1'b0;
			end else begin
				at_start_q <= 1'b0;
				in_strip_q <= in_strip_n;
				held_q     <= held_n;
			end
			cnt_q <= active ? cnt + CNT_W'(1) : cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pos_q        <= active ? pos + 16'd1 : pos;
			open_begin_q <= open_begin_n;
			held_begin_q <= held_begin_n;
			held_end_q   <= held_end_n;
			last_above_q <= last_sample ? 16'd0 : last_above_n;
		end
	end

endmodule

FILE: rtl/core/asf_outq.sv
module asf_outq import asf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	input  logic   pop,
	output logic   valid,
	output logic   room,
	output strip_t head
);

	localparam int PTR_W = $clog2(OUTQ_DEPTH);
	localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

	strip_t           mem_q [OUTQ_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign valid  = cnt_q != '0;
	assign room   = cnt_q <= CNT_W'(OUTQ_DEPTH - 2);
	assign head   = mem_q[rp_q];
	assign do_pop = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PTR_W'(push.cnt);
			rp_q  <= rp_q + PTR_W'(do_pop);
			cnt_q <= cnt_q + CNT_W'(push.cnt) - CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			mem_q[wp_q] <= push.r0;
		if (push.cnt == 2'd2)
			mem_q[wp_q + PTR_W'(1)] <= push.r1;
	end

endmodule

FILE: rtl/core/activity_strip_finder_core.sv
// Channel   | Handshake               | Payload
// ----------+-------------------------+------------------------------------------
// config    | APB psel/penable/pready | paddr[3:0], pwdata[31:0], prdata[31:0]
// input     | in_valid / in_ready     | sample (s16), last_sample
// output    | out_valid / out_ready   | strip_layer, strip_begin, strip_end, last_strip
//
// One input word per cycle while in_ready is high. Each word is evaluated in
// the cycle it is taken and its zero to two strips land in a 4-entry result
// queue, then reach the output in order behind any strips already waiting.
// in_ready drops while fewer than two queue slots are free, so a stalled
// output side backs up into the input once three strips wait: after two or
// three strip-making words, while words that make no strip never block.
// Asynchronous reset clears the queue and the run state; registers read 0.
module activity_strip_finder_core import asf_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// config port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	// sample words
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] sample,
	input  logic               last_sample,
	// strip words
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         strip_layer,
	output logic [15:0]        strip_begin,
	output logic [15:0]        strip_end,
	output logic               last_strip
);

	cfg_t   cfg;
	push_t  push;
	strip_t head;
	logic   room, acc;

	assign pready = 1'b1;

	asf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// Word taken whenever the queue can absorb the worst case of two strips
	assign in_ready = room;
	assign acc      = in_valid && room;

	// Hysteresis run state and strip emission, all in the accept cycle
	asf_step #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.acc         (acc),
		.sample      (sample),
		.last_sample (last_sample),
		.push        (push)
	);

	// Result queue decouples the output handshake from the input side
	asf_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (out_ready),
		.valid  (out_valid),
		.room   (room),
		.head   (head)
	);

	assign strip_layer = head.layer;
	assign strip_begin = head.start_idx;
	assign strip_end   = head.stop_idx;
	assign last_strip  = head.last;

endmodule

FILE: rtl/core/asf_checker.sv
module asf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        in_valid,
	input logic        in_ready,
	input logic [15:0] sample,
	input logic        last_sample,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] strip_begin,
	input logic [15:0] strip_end
);

	// Stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(strip_begin) && $stable(strip_end))
		else $error("stalled strip word changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	// No strip appears without an input word behind it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !(in_valid && in_ready) |=> !out_valid)
		else $error("strip word from nowhere");

	// A non-positive, non-final sample can neither confirm nor flush a strip
	a_quiet_sample: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && in_valid && in_ready && !last_sample
		&& (sample[15] || sample == 16'd0) |=> !out_valid)
		else $error("strip from a quiet sample");

endmodule

bind activity_strip_finder_core asf_checker u_asf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pready      (pready),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.sample      (sample),
	.last_sample (last_sample),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.strip_begin (strip_begin),
	.strip_end   (strip_end)
);
